/* sv/oms_pkg.sv */
// Types, constants and CORDIC angle table for the odometry motion sampler.
// No dependencies; imported by every module of the block.
`default_nettype none

package oms_pkg;

  localparam int CordicIters = 16;
  localparam int SqrtSteps   = 28;

  localparam int VEC_W = 36;   // vectoring CORDIC x/y
  localparam int ROT_W = 33;   // rotation CORDIC x/y, Q.30
  localparam int ANG_W = 20;   // CORDIC angle, Q.16 radians
  localparam int SQ_W  = 56;   // variance and square-root remainder

  localparam int PI_Q16          = 205887;
  localparam int HALF_PI_Q16     = 102944;
  localparam int TWO_PI_Q16      = 411775;
  localparam int CORDIC_GAIN_Q16 = 39797;
  localparam int CORDIC_INIT_Q30 = 652032874;
  // floor(2^44 / (2*pi in Q.16)), for the angle reduction
  localparam int RECIP_2PI   = 42722812;
  localparam int RECIP_SHIFT = 44;

  localparam logic [15:0] ARR_RESET = 16'd6554;
  localparam logic [15:0] ART_RESET = 16'd6554;
  localparam logic [15:0] ATT_RESET = 16'd13107;
  localparam logic [15:0] ATR_RESET = 16'd13107;

  typedef enum logic [1:0] {
    REG_ROT_FROM_ROT     = 2'd0,
    REG_ROT_FROM_TRANS   = 2'd1,
    REG_TRANS_FROM_TRANS = 2'd2,
    REG_TRANS_FROM_ROT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } rot_t;

  // per-item values that ride alongside the datapath
  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [15:0] qh;
    logic signed [15:0] n1;
    logic signed [15:0] nt;
    logic signed [15:0] n2;
    logic signed [16:0] dh;
    logic               zero;
    logic signed [15:0] rot1;
    logic signed [17:0] rot2;
    logic        [30:0] trans;
    logic signed [31:0] transh;
    logic signed [35:0] rot1h;
    logic signed [35:0] rot2h;
    logic signed [15:0] nh;
    logic               neg;
  } side_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* sv/oms_vec_cell.sv */
// One iteration of the vectoring CORDIC (atan2 and magnitude).
// Depends on oms_pkg.
`default_nettype none

module oms_vec_cell #(
  parameter int Idx = 0
) (
  input  logic         clk,
  input  logic         en,
  input  oms_pkg::vec_t d_in,
  output oms_pkg::vec_t d_out
);
  import oms_pkg::*;

  vec_t d_next;

  always_comb begin
    d_next = d_in;
    if (!d_in.y[VEC_W-1]) begin
      d_next.x = d_in.x + (d_in.y >>> Idx);
      d_next.y = d_in.y - (d_in.x >>> Idx);
      d_next.z = d_in.z + atan_q16(Idx);
    end else begin
      d_next.x = d_in.x - (d_in.y >>> Idx);
      d_next.y = d_in.y + (d_in.x >>> Idx);
      d_next.z = d_in.z - atan_q16(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

/* sv/oms_sqrt_cell.sv */
// One bit of a digit-by-digit integer square root.
// Depends on oms_pkg.
`default_nettype none

module oms_sqrt_cell #(
  parameter int Idx = 0
) (
  input  logic          clk,
  input  logic          en,
  input  oms_pkg::sqrt_t d_in,
  output oms_pkg::sqrt_t d_out
);
  import oms_pkg::*;

  localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * (SqrtSteps - 1 - Idx));

  logic [SQ_W:0] trial;
  sqrt_t         d_next;

  always_comb begin
    trial  = {1'b0, d_in.root} + {1'b0, Bit};
    d_next = d_in;
    if ({1'b0, d_in.rem} >= trial) begin
      d_next.rem  = d_in.rem - trial[SQ_W-1:0];
      d_next.root = (d_in.root >> 1) + Bit;
    end else begin
      d_next.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

/* sv/oms_rot_cell.sv */
// One iteration of the rotation CORDIC (cos and sin in Q.30).
// Depends on oms_pkg.
`default_nettype none

module oms_rot_cell #(
  parameter int Idx = 0
) (
  input  logic         clk,
  input  logic         en,
  input  oms_pkg::rot_t d_in,
  output oms_pkg::rot_t d_out
);
  import oms_pkg::*;

  rot_t d_next;

  always_comb begin
    d_next = d_in;
    if (!d_in.z[ANG_W-1]) begin
      d_next.x = d_in.x - (d_in.y >>> Idx);
      d_next.y = d_in.y + (d_in.x >>> Idx);
      d_next.z = d_in.z - atan_q16(Idx);
    end else begin
      d_next.x = d_in.x + (d_in.y >>> Idx);
      d_next.y = d_in.y - (d_in.x >>> Idx);
      d_next.z = d_in.z + atan_q16(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

/* sv/odometry_motion_sample.sv */
// Odometry motion model sampler for one particle per item.
// The path from input accept to m_axis_tvalid runs through the 16-cell vectoring
// CORDIC, the 28-cell square root and the 16-cell rotation CORDIC in series.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or being taken. Reset (rst, synchronous) clears all valid bits
// and loads the alpha registers with their defaults; data registers are not reset.
// Depends on oms_pkg, oms_vec_cell, oms_sqrt_cell, oms_rot_cell.
`default_nettype none

module odometry_motion_sample (
  input  logic         clk,
  input  logic         rst,
  // input item stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] prev_odom_x, [63:32] prev_odom_y, [79:64] prev_odom_heading,
  // [111:80] cur_odom_x, [143:112] cur_odom_y, [159:144] cur_odom_heading,
  // [191:160] particle_x, [223:192] particle_y, [239:224] particle_heading,
  // [255:240] noise_rot1, [271:256] noise_trans, [287:272] noise_rot2
  input  logic [287:0] s_axis_tdata,
  // result item stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] new_x, [63:32] new_y, [79:64] new_heading
  output logic [79:0]  m_axis_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import oms_pkg::*;

  localparam logic signed [ANG_W-1:0] PiA     = ANG_W'(PI_Q16);
  localparam logic signed [ANG_W-1:0] HalfPiA = ANG_W'(HALF_PI_Q16);

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7FFF;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Alpha registers
  // ---------------------------------------------------------------------------
  logic [15:0] alpha_rot_from_rot;
  logic [15:0] alpha_rot_from_trans;
  logic [15:0] alpha_trans_from_trans;
  logic [15:0] alpha_trans_from_rot;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_rot_from_rot     <= ARR_RESET;
      alpha_rot_from_trans   <= ART_RESET;
      alpha_trans_from_trans <= ATT_RESET;
      alpha_trans_from_rot   <= ATR_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROT_FROM_ROT:     alpha_rot_from_rot     <= pwdata[15:0];
        REG_ROT_FROM_TRANS:   alpha_rot_from_trans   <= pwdata[15:0];
        REG_TRANS_FROM_TRANS: alpha_trans_from_trans <= pwdata[15:0];
        REG_TRANS_FROM_ROT:   alpha_trans_from_rot   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROT_FROM_ROT:     prdata = {16'd0, alpha_rot_from_rot};
      REG_ROT_FROM_TRANS:   prdata = {16'd0, alpha_rot_from_trans};
      REG_TRANS_FROM_TRANS: prdata = {16'd0, alpha_trans_from_trans};
      REG_TRANS_FROM_ROT:   prdata = {16'd0, alpha_trans_from_rot};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Global advance: every stage moves together; while the output register holds
  // an item that is not taken, the whole pipeline stalls and no new item enters.
  // ---------------------------------------------------------------------------
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------------------
  // Stage 0: input register, odometry deltas
  // ---------------------------------------------------------------------------
  logic signed [31:0] in_px, in_py, in_cx, in_cy;
  logic signed [15:0] in_ph, in_ch;
  logic               v0;
  logic signed [32:0] dx0, dy0;
  side_t              side0, side0_next;

  assign in_px = s_axis_tdata[31:0];
  assign in_py = s_axis_tdata[63:32];
  assign in_ph = s_axis_tdata[79:64];
  assign in_cx = s_axis_tdata[111:80];
  assign in_cy = s_axis_tdata[143:112];
  assign in_ch = s_axis_tdata[159:144];

  always_comb begin
    side0_next    = '0;
    side0_next.qx = s_axis_tdata[191:160];
    side0_next.qy = s_axis_tdata[223:192];
    side0_next.qh = s_axis_tdata[239:224];
    side0_next.n1 = s_axis_tdata[255:240];
    side0_next.nt = s_axis_tdata[271:256];
    side0_next.n2 = s_axis_tdata[287:272];
    side0_next.dh = 17'(in_ch) - 17'(in_ph);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= 33'(in_cx) - 33'(in_px);
      dy0   <= 33'(in_cy) - 33'(in_py);
      side0 <= side0_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: left half plane is pre-rotated by +-pi/2 on entry
  // ---------------------------------------------------------------------------
  vec_t  vec_d [0:CordicIters];
  side_t side_v [0:CordicIters];
  logic  vec_v [0:CordicIters];

  always_comb begin
    vec_d[0].x = VEC_W'(dx0);
    vec_d[0].y = VEC_W'(dy0);
    vec_d[0].z = '0;
    if (dx0[32]) begin
      if (!dy0[32]) begin
        vec_d[0].x = VEC_W'(dy0);
        vec_d[0].y = -VEC_W'(dx0);
        vec_d[0].z = HalfPiA;
      end else begin
        vec_d[0].x = -VEC_W'(dy0);
        vec_d[0].y = VEC_W'(dx0);
        vec_d[0].z = -HalfPiA;
      end
    end
    side_v[0]      = side0;
    side_v[0].zero = (dx0 == '0) && (dy0 == '0);
  end
  assign vec_v[0] = v0;

  for (genvar k = 0; k < CordicIters; k++) begin : g_vec
    oms_vec_cell #(.Idx(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (vec_d[k]),
      .d_out(vec_d[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_v[k+1] <= side_v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vec_v[k+1] <= 1'b0;
      end else if (en) begin
        vec_v[k+1] <= vec_v[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // T1..T2: rot1, trans, rot2
  // ---------------------------------------------------------------------------
  logic        [34:0] mag;
  logic signed [15:0] rot1_c;
  logic        [50:0] t1_prod;
  side_t              side_t1, side_t1_next, side_t2, side_t2_next;
  logic        [34:0] trans_raw;

  always_comb begin
    mag          = vec_d[CordicIters].x[VEC_W-1] ? '0 : vec_d[CordicIters].x[34:0];
    rot1_c       = 16'((vec_d[CordicIters].z + 20'sd8) >>> 4);
    side_t1_next = side_v[CordicIters];
    side_t1_next.rot1 = side_v[CordicIters].zero ? '0 : rot1_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_prod <= 51'(mag) * 51'(CORDIC_GAIN_Q16);
      side_t1 <= side_t1_next;
    end
  end

  always_comb begin
    trans_raw    = 35'((t1_prod + 51'd32768) >> 16);
    side_t2_next = side_t1;
    if (side_t1.zero) begin
      side_t2_next.trans = '0;
    end else if (trans_raw > 35'h7FFFFFFF) begin
      side_t2_next.trans = 31'h7FFFFFFF;
    end else begin
      side_t2_next.trans = trans_raw[30:0];
    end
    side_t2_next.rot2 = 18'(side_t1.dh) - 18'(side_t1.rot1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_t2 <= side_t2_next;
    end
  end

  // ---------------------------------------------------------------------------
  // T3..T5: squares, alpha weighting, variance sums (Q.24)
  // ---------------------------------------------------------------------------
  logic        [26:0] tr12;
  logic signed [31:0] r1sq;
  logic signed [35:0] r2sq;
  logic        [53:0] sq_t;
  logic        [30:0] sq_1;
  logic        [34:0] sq_2;
  side_t              side_t3, side_t4, side_t5;
  logic        [30:0] m_1r, m_1t;
  logic        [53:0] m_tr, m_tt;
  logic        [34:0] m_2r, m_2t;
  sqrt_t              sq1_d [0:SqrtSteps];
  sqrt_t              sqt_d [0:SqrtSteps];
  sqrt_t              sq2_d [0:SqrtSteps];
  side_t              side_q [0:SqrtSteps];
  logic               sq_v [0:SqrtSteps];

  assign tr12 = side_t2.trans[30:4];
  assign r1sq = side_t2.rot1 * side_t2.rot1;
  assign r2sq = side_t2.rot2 * side_t2.rot2;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_t    <= 54'(tr12) * 54'(tr12);
      sq_1    <= r1sq[30:0];
      sq_2    <= r2sq[34:0];
      side_t3 <= side_t2;
      // alpha * square, floored back to Q.24
      m_1r    <= 31'((47'(sq_1) * 47'(alpha_rot_from_rot)) >> 16);
      m_1t    <= 31'((47'(sq_1) * 47'(alpha_trans_from_rot)) >> 16);
      m_tr    <= 54'((70'(sq_t) * 70'(alpha_rot_from_trans)) >> 16);
      m_tt    <= 54'((70'(sq_t) * 70'(alpha_trans_from_trans)) >> 16);
      m_2r    <= 35'((51'(sq_2) * 51'(alpha_rot_from_rot)) >> 16);
      m_2t    <= 35'((51'(sq_2) * 51'(alpha_trans_from_rot)) >> 16);
      side_t4 <= side_t3;
      sq1_d[0].rem  <= SQ_W'(m_1r) + SQ_W'(m_tr);
      sqt_d[0].rem  <= SQ_W'(m_tt) + SQ_W'(m_1t) + SQ_W'(m_2t);
      sq2_d[0].rem  <= SQ_W'(m_2r) + SQ_W'(m_tr);
      sq1_d[0].root <= '0;
      sqt_d[0].root <= '0;
      sq2_d[0].root <= '0;
      side_t5       <= side_t4;
    end
  end
  assign side_q[0] = side_t5;

  // ---------------------------------------------------------------------------
  // Three square-root chains, one result bit per cell
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    oms_sqrt_cell #(.Idx(k)) u_sig1 (
      .clk(clk), .en(en), .d_in(sq1_d[k]), .d_out(sq1_d[k+1])
    );
    oms_sqrt_cell #(.Idx(k)) u_sigt (
      .clk(clk), .en(en), .d_in(sqt_d[k]), .d_out(sqt_d[k+1])
    );
    oms_sqrt_cell #(.Idx(k)) u_sig2 (
      .clk(clk), .en(en), .d_in(sq2_d[k]), .d_out(sq2_d[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (en) begin
        sq_v[k+1] <= sq_v[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // N1..N3: sigma * noise, perturbed motion, new heading
  // ---------------------------------------------------------------------------
  logic signed [44:0] p1, pt, p2;
  logic signed [44:0] r1_adj, r2_adj, t_adj;
  logic signed [38:0] t_diff;
  side_t              side_n1, side_n2, side_n2_next, side_n3, side_n3_next;
  logic signed [36:0] n3_ang;

  always_ff @(posedge clk) begin
    if (en) begin
      p1      <= $signed({1'b0, sq1_d[SqrtSteps].root[SqrtSteps-1:0]}) * side_q[SqrtSteps].n1;
      pt      <= $signed({1'b0, sqt_d[SqrtSteps].root[SqrtSteps-1:0]}) * side_q[SqrtSteps].nt;
      p2      <= $signed({1'b0, sq2_d[SqrtSteps].root[SqrtSteps-1:0]}) * side_q[SqrtSteps].n2;
      side_n1 <= side_q[SqrtSteps];
    end
  end

  always_comb begin
    r1_adj       = (p1 + 45'sd2048) >>> 12;
    r2_adj       = (p2 + 45'sd2048) >>> 12;
    t_adj        = (pt + 45'sd128) >>> 8;
    t_diff       = $signed({8'd0, side_n1.trans}) - 39'(t_adj);
    side_n2_next = side_n1;
    side_n2_next.rot1h  = 36'(side_n1.rot1) - 36'(r1_adj);
    side_n2_next.rot2h  = 36'(side_n1.rot2) - 36'(r2_adj);
    side_n2_next.transh = sat32(40'(t_diff));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_n2 <= side_n2_next;
    end
  end

  always_comb begin
    side_n3_next    = side_n2;
    side_n3_next.nh = sat16(40'(side_n2.qh) + 40'(side_n2.rot1h) + 40'(side_n2.rot2h));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_ang  <= 37'(side_n2.qh) + 37'(side_n2.rot1h);
      side_n3 <= side_n3_next;
    end
  end

  // ---------------------------------------------------------------------------
  // N4..N6: angle to Q.16, reduced mod 2*pi into [-pi, pi] by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic signed [40:0] n4_a, n5_a;
  logic signed [67:0] n4_prod;
  logic signed [23:0] n5_q;
  logic signed [43:0] n5_qm;
  logic signed [43:0] n6_r;
  logic signed [ANG_W-1:0] z_red, z_red_next;
  side_t              side_n4, side_n5, side_n6;

  assign n5_q = n4_prod[67:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en) begin
      n4_a    <= {n3_ang, 4'd0};
      n4_prod <= 68'($signed({n3_ang, 4'd0})) * 68'(RECIP_2PI);
      side_n4 <= side_n3;
      n5_a    <= n4_a;
      n5_qm   <= 44'(n5_q) * 44'(TWO_PI_Q16);
      side_n5 <= side_n4;
    end
  end

  // remainder lands in [-2pi, 4pi) since the quotient is off by at most one
  always_comb begin
    n6_r = 44'(n5_a) - n5_qm;
    if (n6_r > 44'(PI_Q16 + TWO_PI_Q16)) begin
      z_red_next = ANG_W'(n6_r - 44'(2 * TWO_PI_Q16));
    end else if (n6_r > 44'(PI_Q16)) begin
      z_red_next = ANG_W'(n6_r - 44'(TWO_PI_Q16));
    end else if (n6_r < -44'(PI_Q16)) begin
      z_red_next = ANG_W'(n6_r + 44'(TWO_PI_Q16));
    end else begin
      z_red_next = ANG_W'(n6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_red   <= z_red_next;
      side_n6 <= side_n5;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation CORDIC: folded into [-pi/2, pi/2] on entry, sign restored after
  // ---------------------------------------------------------------------------
  rot_t  rot_d [0:CordicIters];
  side_t side_r [0:CordicIters];
  logic  rot_v [0:CordicIters];

  always_comb begin
    rot_d[0].x    = ROT_W'(CORDIC_INIT_Q30);
    rot_d[0].y    = '0;
    rot_d[0].z    = z_red;
    side_r[0]     = side_n6;
    side_r[0].neg = 1'b0;
    if (z_red > HalfPiA) begin
      rot_d[0].z    = z_red - PiA;
      side_r[0].neg = 1'b1;
    end else if (z_red < -HalfPiA) begin
      rot_d[0].z    = z_red + PiA;
      side_r[0].neg = 1'b1;
    end
  end

  for (genvar k = 0; k < CordicIters; k++) begin : g_rot
    oms_rot_cell #(.Idx(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (rot_d[k]),
      .d_out(rot_d[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k+1] <= side_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rot_v[k+1] <= 1'b0;
      end else if (en) begin
        rot_v[k+1] <= rot_v[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // F1..F2: move the pose, output register
  // ---------------------------------------------------------------------------
  logic signed [ROT_W-1:0] c_q30, s_q30;
  logic signed [64:0]      f1_px, f1_py;
  side_t                   side_f1;
  logic signed [31:0]      nx, ny;

  assign c_q30 = side_r[CordicIters].neg ? -rot_d[CordicIters].x : rot_d[CordicIters].x;
  assign s_q30 = side_r[CordicIters].neg ? -rot_d[CordicIters].y : rot_d[CordicIters].y;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_px   <= 65'(side_r[CordicIters].transh) * 65'(c_q30);
      f1_py   <= 65'(side_r[CordicIters].transh) * 65'(s_q30);
      side_f1 <= side_r[CordicIters];
    end
  end

  assign nx = sat32(40'((f1_px + 65'sd536870912) >>> 30) + 40'(side_f1.qx));
  assign ny = sat32(40'((f1_py + 65'sd536870912) >>> 30) + 40'(side_f1.qy));

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {side_f1.nh, ny, nx};
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------------
  logic v_t1, v_t2, v_t3, v_t4, v_t5, v_n1, v_n2, v_n3, v_n4, v_n5, v_n6, v_f1;

  assign sq_v[0]  = v_t5;
  assign rot_v[0] = v_n6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0            <= 1'b0;
      v_t1          <= 1'b0;
      v_t2          <= 1'b0;
      v_t3          <= 1'b0;
      v_t4          <= 1'b0;
      v_t5          <= 1'b0;
      v_n1          <= 1'b0;
      v_n2          <= 1'b0;
      v_n3          <= 1'b0;
      v_n4          <= 1'b0;
      v_n5          <= 1'b0;
      v_n6          <= 1'b0;
      v_f1          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v0            <= s_axis_tvalid;
      v_t1          <= vec_v[CordicIters];
      v_t2          <= v_t1;
      v_t3          <= v_t2;
      v_t4          <= v_t3;
      v_t5          <= v_t4;
      v_n1          <= sq_v[SqrtSteps];
      v_n2          <= v_n1;
      v_n3          <= v_n2;
      v_n4          <= v_n3;
      v_n5          <= v_n4;
      v_n6          <= v_n5;
      v_f1          <= rot_v[CordicIters];
      m_axis_tvalid <= v_f1;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_zero_motion: assert property (@(posedge clk) disable iff (rst)
    (v_t2 && side_t2.zero) |-> (side_t2.trans == '0 && side_t2.rot1 == '0))
    else $error("coincident odometry gave nonzero rot1 or trans");

  a_reduced_range: assert property (@(posedge clk) disable iff (rst)
    v_n6 |-> (z_red <= PiA && z_red >= -PiA))
    else $error("angle reduction left [-pi, pi]");

  a_folded_range: assert property (@(posedge clk) disable iff (rst)
    rot_v[0] |-> (rot_d[0].z <= HalfPiA && rot_d[0].z >= -HalfPiA))
    else $error("sin/cos input not folded into [-pi/2, pi/2]");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v_t3) && $stable(v_n3) && $stable(v_f1)))
    else $error("pipeline moved while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    (en && !v_f1) |=> !m_axis_tvalid)
    else $error("result item without an item behind it");

endmodule

`default_nettype wire
